>>> sv/edacc_pkg.sv
`timescale 1ns / 1ps

package edacc_pkg;

	// Default element width, signed two's complement (Q8.8 at 16 bits)
	localparam int ELEMENT_BITS_DEF = 16;

	// Running sum of squares and result widths
	localparam int SUM_W  = 48;
	localparam int DIST_W = 24;

	localparam logic [SUM_W-1:0] SUM_MAX  = '1;
	// First trial bit of the root iteration: highest even power of two in the sum
	localparam logic [SUM_W-1:0] BIT_INIT = {2'b01, {(SUM_W-2){1'b0}}};

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_FLUSH,
		ST_ROOT,
		ST_FINISH
	} edacc_state_t;

	// Controller to datapath
	typedef struct packed {
		logic in_take;
		logic root_load;
		logic out_load;
	} edacc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_add;
		logic root_last;
	} edacc_sts_t;

endpackage

>>> sv/euclidean_distance_accumulator.sv
`timescale 1ns / 1ps
// Throughput: one element pair per cycle while a vector streams in.
// Path from the last pair accepted to distance valid: magnitude stage, square stage, one accumulate
// and root load, 24 root steps on the shared 48-bit compare/subtract unit, one output load.
// Input is held off from the last pair until the result is loaded, longer while the
// previous result still waits. Reset (arst_n low, asynchronous) clears the sum,
// saturation flag and output valid.

module euclidean_distance_accumulator #(
	parameter int ELEMENT_BITS = edacc_pkg::ELEMENT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ELEMENT_BITS-1:0]    a_value,
	input  logic signed [ELEMENT_BITS-1:0]    b_value,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [edacc_pkg::DIST_W-1:0]      distance,
	output logic                              saturated
);

	edacc_pkg::edacc_cmd_t cmd;
	edacc_pkg::edacc_sts_t sts;

	edacc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	edacc_dp #(
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.a_value   (a_value),
		.b_value   (b_value),
		.last      (last),
		.cmd       (cmd),
		.sts       (sts),
		.distance  (distance),
		.saturated (saturated)
	);

endmodule

>>> sv/edacc_dp.sv
`timescale 1ns / 1ps

module edacc_dp #(
	parameter int ELEMENT_BITS = edacc_pkg::ELEMENT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [ELEMENT_BITS-1:0]    a_value,
	input  logic signed [ELEMENT_BITS-1:0]    b_value,
	input  logic                              last,
	input  edacc_pkg::edacc_cmd_t             cmd,
	output edacc_pkg::edacc_sts_t             sts,
	output logic [edacc_pkg::DIST_W-1:0]      distance,
	output logic                              saturated
);

	localparam int MAG_W = ELEMENT_BITS + 1;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int ADD_W = ((SQ_W > edacc_pkg::SUM_W) ? SQ_W : edacc_pkg::SUM_W) + 1;

	logic signed [MAG_W-1:0]        diff;
	logic [MAG_W-1:0]               mag_s1;
	logic                           v_s1;
	logic                           last_s1;
	logic [SQ_W-1:0]                sq_s2;
	logic                           v_s2;
	logic                           last_s2;
	logic [edacc_pkg::SUM_W-1:0]    sum_q;
	logic                           ovf_q;
	logic [ADD_W-1:0]               add_wide;
	logic                           over;
	logic [edacc_pkg::SUM_W-1:0]    sum_next;
	logic                           ovf_next;
	logic [edacc_pkg::SUM_W-1:0]    rem_q;
	logic [edacc_pkg::SUM_W-1:0]    root_q;
	logic [edacc_pkg::SUM_W-1:0]    bit_q;
	logic                           sat_q;
	logic [edacc_pkg::SUM_W:0]      trial;
	logic                           take;

	// Stage 1: exact difference and its magnitude
	assign diff = MAG_W'(a_value) - MAG_W'(b_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1    <= cmd.in_take;
			last_s1 <= cmd.in_take & last;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
		sq_s2  <= SQ_W'(mag_s1) * SQ_W'(mag_s1);
	end

	// Saturating accumulate of the square
	assign add_wide = ADD_W'(sum_q) + ADD_W'(sq_s2);
	assign over     = add_wide > ADD_W'(edacc_pkg::SUM_MAX);
	assign sum_next = !v_s2 ? sum_q :
		(over ? edacc_pkg::SUM_MAX : add_wide[edacc_pkg::SUM_W-1:0]);
	assign ovf_next = ovf_q | (v_s2 & over);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.root_load) begin
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			sum_q <= sum_next;
			ovf_q <= ovf_next;
		end
	end

	// Restoring square root, one result bit per cycle
	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign take  = {1'b0, rem_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (cmd.root_load) begin
			bit_q <= edacc_pkg::BIT_INIT;
		end else begin
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.root_load) begin
			rem_q  <= sum_next;
			root_q <= '0;
			sat_q  <= ovf_next;
		end else if (bit_q != '0) begin
			if (take) begin
				rem_q  <= rem_q - trial[edacc_pkg::SUM_W-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
		end
	end

	// Hold the finished result
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			distance  <= root_q[edacc_pkg::DIST_W-1:0];
			saturated <= sat_q;
		end
	end

	assign sts.last_add  = v_s2 & last_s2;
	assign sts.root_last = bit_q[0];

	// No pair may follow the closing pair into the pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && last_s2) |-> !v_s1)
		else $error("pair entered behind closing pair");

	// Trial bit walks down as a single bit
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(bit_q))
		else $error("root trial bit corrupted");

	// A closing flag only rides on a valid pair
	assert property (@(posedge clk) disable iff (!arst_n)
		last_s2 |-> v_s2)
		else $error("closing flag without pair");

endmodule

>>> sv/edacc_ctrl.sv
`timescale 1ns / 1ps

module edacc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   last,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output edacc_pkg::edacc_cmd_t  cmd,
	input  edacc_pkg::edacc_sts_t  sts
);

	edacc_pkg::edacc_state_t state_q;
	edacc_pkg::edacc_state_t state_next;
	logic                    out_valid_q;
	logic                    out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			edacc_pkg::ST_ACCUM: begin
				if (in_valid && last) state_next = edacc_pkg::ST_FLUSH;
			end
			edacc_pkg::ST_FLUSH: begin
				if (sts.last_add) state_next = edacc_pkg::ST_ROOT;
			end
			edacc_pkg::ST_ROOT: begin
				if (sts.root_last) state_next = edacc_pkg::ST_FINISH;
			end
			edacc_pkg::ST_FINISH: begin
				if (out_free) state_next = edacc_pkg::ST_ACCUM;
			end
			default: state_next = edacc_pkg::ST_ACCUM;
		endcase
	end

	// Commands
	always_comb begin
		in_ready      = 1'b0;
		cmd.in_take   = 1'b0;
		cmd.root_load = 1'b0;
		cmd.out_load  = 1'b0;
		case (state_q)
			edacc_pkg::ST_ACCUM: begin
				in_ready    = 1'b1;
				cmd.in_take = in_valid;
			end
			edacc_pkg::ST_FLUSH: begin
				cmd.root_load = sts.last_add;
			end
			edacc_pkg::ST_FINISH: begin
				cmd.out_load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= edacc_pkg::ST_ACCUM;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Closing pair reaches the adder only while draining
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.last_add |-> (state_q == edacc_pkg::ST_FLUSH))
		else $error("closing pair added outside drain");

	// Root iteration finishes only while rooting
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.root_last |-> (state_q == edacc_pkg::ST_ROOT))
		else $error("root finished outside root state");

	// Stay in root until the last step
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == edacc_pkg::ST_ROOT && !sts.root_last) |=> (state_q == edacc_pkg::ST_ROOT))
		else $error("root state left early");

endmodule
